// ===== rtl/clcqs_pkg.sv =====
// Shared types and constants for the character-LCD command queue sequencer.
package clcqs_pkg;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] value;
	} req_t;

	typedef struct packed {
		logic       kind;
		logic       port;
		logic [7:0] port_value;
		logic       busy_indicator;
		logic       overflow;
		logic       last;
	} rsp_t;

	localparam logic [1:0] CMD_INSTR = 2'd0;
	localparam logic [1:0] CMD_DATA  = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	localparam logic [7:0]  MARKER      = 8'hFF;
	localparam logic [7:0]  SUBST_CHAR  = 8'h78;
	localparam logic [7:0]  CTRL_RS     = 8'h80;
	localparam logic [7:0]  CTRL_E      = 8'h40;
	localparam logic [7:0]  CTRL_IDLE   = 8'h00;
	localparam logic [15:0] DELAY_RESET = 16'd30;

	localparam logic KIND_PORT   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;
	localparam logic PORT_CTRL   = 1'b0;
	localparam logic PORT_DATA   = 1'b1;

	// What the back end has to play out for one word from the front end
	typedef enum logic [1:0] {
		JOB_STATUS,
		JOB_MARK,
		JOB_IWR,
		JOB_DWR
	} job_t;

	typedef struct packed {
		job_t       job;
		logic [7:0] data;
		logic       busy;
		logic       ovf;
	} job_desc_t;

	// Queue entry: instruction flag and byte
	typedef struct packed {
		logic       instr;
		logic [7:0] data;
	} entry_t;

endpackage

// ===== rtl/char_lcd_command_queue_sequencer_top.sv =====
// Top level of the character-LCD command queue sequencer.
// The first result word of a request passes the job queue, then the output register, to rsp.
// Throughput: one request word a cycle unless the job queue is full; results leave at one
// word a cycle unless rsp_stall is high, and a request makes up to four (job queue absorbs bursts).
// Reset: pointers, sequencer and indicator clear at once, delay returns to 30 ticks;
// the ring store is not cleared, so no clearing pass and no dead cycles after reset.
module char_lcd_command_queue_sequencer_top #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  clcqs_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output clcqs_pkg::rsp_t rsp,
	input  logic            cfg_wr_en,
	input  logic [15:0]     cfg_wr_data
);

	logic                 job_push, job_full, job_pop, job_valid;
	clcqs_pkg::job_desc_t job_in, job_head;

	// Hold request words whenever the job queue has no free slot
	assign req_stall = job_full;

	// Front end: queue bookkeeping, delay counting, indicator level
	clcqs_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.job_push   (job_push),
		.job        (job_in)
	);

	// Decouple the two ends so each can stall on its own
	clcqs_jobq u_jobq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_job  (job_in),
		.full      (job_full),
		.pop       (job_pop),
		.head_valid(job_valid),
		.head_job  (job_head)
	);

	// Back end: advance through the port writes or status word of each job, one word a cycle while rsp_stall is low
	clcqs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(job_valid),
		.job      (job_head),
		.job_pop  (job_pop),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule

// ===== rtl/clcqs_ram.sv =====
// Generic single-port-write, registered-read RAM (read-first).
module clcqs_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/clcqs_front.sv =====
// Front end: takes request words, keeps the ring store and the tick sequencer.
module clcqs_front #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_stall,
	input  clcqs_pkg::req_t     req,
	input  logic                cfg_wr_en,
	input  logic [15:0]         cfg_wr_data,
	output logic                job_push,
	output clcqs_pkg::job_desc_t job
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST    = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [PTR_W-1:0] USED_I_MAX  = PTR_W'(QUEUE_DEPTH - 3);
	localparam logic [PTR_W-1:0] USED_D_MAX  = PTR_W'(QUEUE_DEPTH - 2);

	typedef enum logic [1:0] {
		M_IDLE,
		M_WAIT,
		M_IWRITE,
		M_DWRITE
	} mode_t;

	mode_t              mode_q, mode_d, after_q, after_d;
	logic [15:0]        delay_q;
	logic [15:0]        wait_q, wait_d;
	logic [7:0]         pend_q, pend_d;
	logic               ind_q, ind_d;
	logic [PTR_W-1:0]   rd_q, rd_d, wr_q, wr_d;
	logic [PTR_W-1:0]   used_q, used_d;
	logic               byp_hit_q;
	clcqs_pkg::entry_t  byp_q, head, ram_wdata, ram_rdata;
	logic               ram_we;
	logic               accept, ovf;

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	assign accept = req_valid & ~req_stall;
	assign head   = byp_hit_q ? byp_q : ram_rdata;

	always_comb begin
		mode_d    = mode_q;
		after_d   = after_q;
		wait_d    = wait_q;
		pend_d    = pend_q;
		ind_d     = ind_q;
		rd_d      = rd_q;
		wr_d      = wr_q;
		used_d    = used_q;
		ram_we    = 1'b0;
		ram_wdata = '0;
		ovf       = 1'b0;
		job_push  = 1'b0;
		job.job   = clcqs_pkg::JOB_STATUS;
		job.data  = '0;
		if (accept) begin
			case (req.cmd) inside
				clcqs_pkg::CMD_INSTR, clcqs_pkg::CMD_DATA: begin
					job_push = 1'b1;
					if (req.cmd == clcqs_pkg::CMD_INSTR) begin
						ovf = used_q > USED_I_MAX;
						ram_wdata.instr = 1'b1;
						ram_wdata.data  = req.value;
						used_d = used_q + PTR_W'(2);
					end else begin
						ovf = used_q > USED_D_MAX;
						ram_wdata.instr = 1'b0;
						ram_wdata.data  = (req.value == clcqs_pkg::MARKER) ?
							clcqs_pkg::SUBST_CHAR : req.value;
						used_d = used_q + PTR_W'(1);
					end
					if (ovf) begin
						used_d = used_q;
					end else begin
						ram_we = 1'b1;
						wr_d   = ring_next(wr_q);
					end
				end
				clcqs_pkg::CMD_TICK: begin
					unique case (mode_q)
						M_IDLE: begin
							if (used_q != '0) begin
								ind_d  = 1'b1;
								mode_d = M_WAIT;
								wait_d = delay_q;
								used_d = used_q - 1'b1;
								if (head.instr) begin
									// marker popped; the byte stays at the head
									after_d  = M_IWRITE;
									job_push = 1'b1;
									job.job  = clcqs_pkg::JOB_MARK;
								end else begin
									after_d = M_DWRITE;
									pend_d  = head.data;
									rd_d    = ring_next(rd_q);
								end
							end
						end
						M_WAIT: begin
							if (wait_q <= 16'd1) begin
								wait_d = '0;
								ind_d  = 1'b0;
								mode_d = after_q;
							end else begin
								wait_d = wait_q - 1'b1;
							end
						end
						M_IWRITE: begin
							if (used_q != '0) begin
								job.data = head.data;
								used_d   = used_q - 1'b1;
								rd_d     = ring_next(rd_q);
							end
							job_push = 1'b1;
							job.job  = clcqs_pkg::JOB_IWR;
							mode_d   = M_IDLE;
						end
						M_DWRITE: begin
							job_push = 1'b1;
							job.job  = clcqs_pkg::JOB_DWR;
							job.data = pend_q;
							mode_d   = M_IDLE;
						end
						default: begin
							mode_d = M_IDLE;
						end
					endcase
				end
				default: begin
				end
			endcase
		end
		job.busy = ind_d;
		job.ovf  = ovf;
	end

	clcqs_ram #(
		.WIDTH ($bits(clcqs_pkg::entry_t)),
		.DEPTH (QUEUE_DEPTH),
		.ADDR_W(PTR_W)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_q),
		.wdata(ram_wdata),
		.raddr(rd_d),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= M_IDLE;
			after_q   <= M_IDLE;
			wait_q    <= '0;
			pend_q    <= '0;
			ind_q     <= 1'b0;
			rd_q      <= '0;
			wr_q      <= '0;
			used_q    <= '0;
			delay_q   <= clcqs_pkg::DELAY_RESET;
			byp_hit_q <= 1'b0;
		end else begin
			mode_q    <= mode_d;
			after_q   <= after_d;
			wait_q    <= wait_d;
			pend_q    <= pend_d;
			ind_q     <= ind_d;
			rd_q      <= rd_d;
			wr_q      <= wr_d;
			used_q    <= used_d;
			byp_hit_q <= ram_we && (wr_q == rd_d);
			if (cfg_wr_en) begin
				delay_q <= cfg_wr_data;
			end
		end
	end

	// forward a write that lands on the head address in the same cycle
	always_ff @(posedge clk) begin
		byp_q <= ram_wdata;
	end

endmodule

// ===== rtl/clcqs_jobq.sv =====
// Short job queue between the front and back ends.
module clcqs_jobq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  clcqs_pkg::job_desc_t push_job,
	output logic                 full,
	input  logic                 pop,
	output logic                 head_valid,
	output clcqs_pkg::job_desc_t head_job
);

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	clcqs_pkg::job_desc_t slot_q [DEPTH];
	logic [PTR_W-1:0]     rd_q, wr_q;
	logic [PTR_W:0]       cnt_q;
	logic                 do_push, do_pop;

	assign full       = cnt_q == (PTR_W + 1)'(DEPTH);
	assign head_valid = cnt_q != '0;
	assign head_job   = slot_q[rd_q];
	assign do_push    = push & ~full;
	assign do_pop     = pop & head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (PTR_W + 1)'(do_push) - (PTR_W + 1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_job;
		end
	end

endmodule

// ===== rtl/clcqs_back.sv =====
// Back end: expands each job into expander port writes or a status word.
module clcqs_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 job_valid,
	input  clcqs_pkg::job_desc_t job,
	output logic                 job_pop,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output clcqs_pkg::rsp_t      rsp
);

	logic [1:0]      step_q;
	logic            load, fin;
	clcqs_pkg::rsp_t word;
	clcqs_pkg::rsp_t rsp_q;
	logic            rsp_valid_q;

	always_comb begin
		word.kind           = clcqs_pkg::KIND_PORT;
		word.port           = clcqs_pkg::PORT_CTRL;
		word.port_value     = clcqs_pkg::CTRL_IDLE;
		word.busy_indicator = job.busy;
		word.overflow       = 1'b0;
		fin                 = 1'b0;
		unique case (job.job)
			clcqs_pkg::JOB_STATUS: begin
				word.kind     = clcqs_pkg::KIND_STATUS;
				word.overflow = job.ovf;
				fin           = 1'b1;
			end
			clcqs_pkg::JOB_MARK: begin
				fin = 1'b1;
			end
			clcqs_pkg::JOB_IWR: begin
				case (step_q)
					2'd0: begin
						word.port       = clcqs_pkg::PORT_DATA;
						word.port_value = job.data;
					end
					2'd1: word.port_value = clcqs_pkg::CTRL_E;
					default: fin = 1'b1;
				endcase
			end
			clcqs_pkg::JOB_DWR: begin
				case (step_q)
					2'd0: word.port_value = clcqs_pkg::CTRL_RS;
					2'd1: begin
						word.port       = clcqs_pkg::PORT_DATA;
						word.port_value = job.data;
					end
					2'd2: word.port_value = clcqs_pkg::CTRL_RS | clcqs_pkg::CTRL_E;
					default: fin = 1'b1;
				endcase
			end
			default: fin = 1'b1;
		endcase
		word.last = fin;
	end

	assign load      = ~rsp_valid_q | ~rsp_stall;
	assign job_pop   = load & job_valid & fin;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			step_q      <= '0;
		end else if (load) begin
			rsp_valid_q <= job_valid;
			if (job_valid) begin
				step_q <= fin ? 2'd0 : step_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && job_valid) begin
			rsp_q <= word;
		end
	end

endmodule

// ===== tb/sv/char_lcd_command_queue_sequencer_top_tb.sv =====
// Self-checking testbench for the character-LCD command queue sequencer top level.
`timescale 1ns / 100ps

module char_lcd_command_queue_sequencer_top_tb;

	// Opcode the block has no use for: it must be dropped without a word
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int RING_DEPTH = 64;
	// Settling time after the last awaited word before the block counts as idle
	localparam int DRAIN_CYCLES = 16;
	// Printing stops past this many mismatches; counting goes on
	localparam int PRINT_CAP = 200;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_WAIT,
		SEQ_INSTR_WR,
		SEQ_DATA_WR
	} seq_mode_t;

	logic              clk;
	logic              arst_n;
	logic              req_valid;
	logic              req_stall;
	clcqs_pkg::req_t   req;
	logic              rsp_valid;
	logic              rsp_stall;
	clcqs_pkg::rsp_t   rsp;
	logic              cfg_wr_en;
	logic [15:0]       cfg_wr_data;

	// Shadow of the display sequencer, advanced once per accepted request word
	logic [7:0]  ring_bytes [RING_DEPTH];
	logic [5:0]  wr_ptr;
	logic [5:0]  rd_ptr;
	seq_mode_t   seq_mode;
	seq_mode_t   mode_after_wait;
	logic [15:0] wait_left;
	logic [7:0]  held_char;
	logic        busy_level;
	logic [15:0] delay_ticks;

	clcqs_pkg::rsp_t awaited_words[$];
	int   mismatch_count = 0;
	bit   idle_on = 1'b1;
	int   hold_left = 0;

	char_lcd_command_queue_sequencer_top #(
		.QUEUE_DEPTH(RING_DEPTH)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run, held-off receiver included
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	task automatic flag_mismatch(string msg);
		if (mismatch_count < PRINT_CAP)
			$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	function automatic clcqs_pkg::req_t lcd_word(logic [1:0] c, logic [7:0] v);
		return '{cmd: c, value: v};
	endfunction

	function automatic void reset_lcd_model();
		wr_ptr          = '0;
		rd_ptr          = '0;
		seq_mode        = SEQ_IDLE;
		mode_after_wait = SEQ_IDLE;
		wait_left       = '0;
		held_char       = '0;
		busy_level      = 1'b0;
		delay_ticks     = clcqs_pkg::DELAY_RESET;
	endfunction

	// Queue one awaited word; the busy level is the one after this request's update
	function automatic void await_word(logic kind, logic port, logic [7:0] val, logic ovf);
		awaited_words.push_back('{kind: kind, port: port, port_value: val,
			busy_indicator: busy_level, overflow: ovf, last: 1'b0});
	endfunction

	// Work out the words one accepted request produces and update the shadow state
	function automatic void advance_lcd_sequencer(clcqs_pkg::req_t w);
		logic [5:0] fill;
		int         used;
		int         need;
		int         first_new;
		logic       ovf;
		logic [7:0] popped;

		// ring distance wraps at the pointer width
		fill      = wr_ptr - rd_ptr;
		used      = int'(fill);
		first_new = awaited_words.size();
		case (w.cmd)
			clcqs_pkg::CMD_INSTR, clcqs_pkg::CMD_DATA: begin
				need = (w.cmd == clcqs_pkg::CMD_INSTR) ? 2 : 1;
				ovf  = (RING_DEPTH - 1 - used) < need;
				if (!ovf) begin
					if (w.cmd == clcqs_pkg::CMD_INSTR) begin
						ring_bytes[wr_ptr] = clcqs_pkg::MARKER;
						wr_ptr++;
						ring_bytes[wr_ptr] = w.value;
						wr_ptr++;
					end else begin
						ring_bytes[wr_ptr] = (w.value == clcqs_pkg::MARKER) ?
							clcqs_pkg::SUBST_CHAR : w.value;
						wr_ptr++;
					end
				end
				await_word(clcqs_pkg::KIND_STATUS, clcqs_pkg::PORT_CTRL,
					clcqs_pkg::CTRL_IDLE, ovf);
			end
			clcqs_pkg::CMD_TICK: begin
				case (seq_mode)
					SEQ_IDLE: begin
						if (used != 0) begin
							popped = ring_bytes[rd_ptr];
							rd_ptr++;
							busy_level = 1'b1;
							seq_mode   = SEQ_WAIT;
							wait_left  = delay_ticks;
							if (popped == clcqs_pkg::MARKER) begin
								mode_after_wait = SEQ_INSTR_WR;
								await_word(clcqs_pkg::KIND_PORT, clcqs_pkg::PORT_CTRL,
									clcqs_pkg::CTRL_IDLE, 1'b0);
							end else begin
								mode_after_wait = SEQ_DATA_WR;
								held_char = popped;
							end
						end
					end
					SEQ_WAIT: begin
						if (wait_left <= 16'd1) begin
							wait_left  = '0;
							busy_level = 1'b0;
							seq_mode   = mode_after_wait;
						end else begin
							wait_left--;
						end
					end
					SEQ_INSTR_WR: begin
						popped = clcqs_pkg::CTRL_IDLE;
						if (used != 0) begin
							popped = ring_bytes[rd_ptr];
							rd_ptr++;
						end
						await_word(clcqs_pkg::KIND_PORT, clcqs_pkg::PORT_DATA, popped, 1'b0);
						await_word(clcqs_pkg::KIND_PORT, clcqs_pkg::PORT_CTRL,
							clcqs_pkg::CTRL_E, 1'b0);
						await_word(clcqs_pkg::KIND_PORT, clcqs_pkg::PORT_CTRL,
							clcqs_pkg::CTRL_IDLE, 1'b0);
						seq_mode = SEQ_IDLE;
					end
					default: begin
						await_word(clcqs_pkg::KIND_PORT, clcqs_pkg::PORT_CTRL,
							clcqs_pkg::CTRL_RS, 1'b0);
						await_word(clcqs_pkg::KIND_PORT, clcqs_pkg::PORT_DATA, held_char, 1'b0);
						await_word(clcqs_pkg::KIND_PORT, clcqs_pkg::PORT_CTRL,
							clcqs_pkg::CTRL_RS | clcqs_pkg::CTRL_E, 1'b0);
						await_word(clcqs_pkg::KIND_PORT, clcqs_pkg::PORT_CTRL,
							clcqs_pkg::CTRL_IDLE, 1'b0);
						seq_mode = SEQ_IDLE;
					end
				endcase
			end
			default: ;
		endcase
		if (awaited_words.size() > first_new)
			awaited_words[awaited_words.size() - 1].last = 1'b1;
	endfunction

	task automatic compare_field(string name, logic [7:0] got, logic [7:0] want);
		if (got !== want)
			flag_mismatch($sformatf("%s got %h, want %h", name, got, want));
	endtask

	task automatic check_lcd_word(clcqs_pkg::rsp_t got);
		clcqs_pkg::rsp_t want;

		if (awaited_words.size() == 0) begin
			flag_mismatch($sformatf("word %h arrived with nothing awaited", got));
			return;
		end
		want = awaited_words.pop_front();
		compare_field("kind", 8'(got.kind), 8'(want.kind));
		compare_field("port", 8'(got.port), 8'(want.port));
		compare_field("port_value", got.port_value, want.port_value);
		compare_field("busy_indicator", 8'(got.busy_indicator), 8'(want.busy_indicator));
		compare_field("overflow", 8'(got.overflow), 8'(want.overflow));
		compare_field("last", 8'(got.last), 8'(want.last));
	endtask

	// Receiving side: check each word taken at an edge, then pick the next stall.
	// A hold request keeps stall high while hold_left, counted down here, is above zero.
	initial begin
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall)
				check_lcd_word(rsp);
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else begin
				rsp_stall <= idle_on && ($urandom_range(0, 99) < 33);
			end
		end
	end

	// Sending side: idle at random, then hold the word until the block takes it.
	// Valid stays high on return so back-to-back words need no second assignment.
	task automatic offer_word(clcqs_pkg::req_t w);
		if (idle_on) begin
			while ($urandom_range(0, 99) < 33) begin
				req_valid <= 1'b0;
				req       <= '{cmd: 2'($urandom), value: 8'($urandom)};
				@(posedge clk);
			end
		end
		req_valid <= 1'b1;
		req       <= w;
		do @(posedge clk); while (req_stall);
		advance_lcd_sequencer(w);
	endtask

	// Pause the sender until every awaited word is in, then let stragglers settle
	task automatic wait_results_drained();
		req_valid <= 1'b0;
		while (awaited_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Tick until the shadow says the ring is empty and the sequencer is back in idle
	task automatic play_out_queue();
		while (seq_mode != SEQ_IDLE || wr_ptr != rd_ptr)
			offer_word(lcd_word(clcqs_pkg::CMD_TICK, 8'($urandom)));
	endtask

	task automatic write_delay(logic [15:0] ticks);
		wait_results_drained();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= ticks;
		@(posedge clk);
		delay_ticks = ticks;
		cfg_wr_en   <= 1'b0;
	endtask

	function automatic clcqs_pkg::req_t random_lcd_word();
		int         pick;
		logic [7:0] v;

		pick = $urandom_range(0, 99);
		v    = ($urandom_range(0, 7) == 0) ? clcqs_pkg::MARKER : 8'($urandom);
		if (pick < 20)
			return lcd_word(clcqs_pkg::CMD_INSTR, v);
		if (pick < 45)
			return lcd_word(clcqs_pkg::CMD_DATA, v);
		if (pick < 95)
			return lcd_word(clcqs_pkg::CMD_TICK, v);
		return lcd_word(CMD_UNUSED, v);
	endfunction

	// Untouched delay from reset: a clear, then ticks on an empty ring
	task automatic test_reset_delay();
		offer_word(lcd_word(clcqs_pkg::CMD_INSTR, 8'h01));
		play_out_queue();
		offer_word(lcd_word(clcqs_pkg::CMD_TICK, 8'h00));
		offer_word(lcd_word(clcqs_pkg::CMD_TICK, 8'hFF));
		wait_results_drained();
	endtask

	// Byte extremes for both request kinds, marker substitution, unused opcode
	task automatic test_field_extremes();
		write_delay(16'd1);
		offer_word(lcd_word(clcqs_pkg::CMD_INSTR, 8'h00));
		offer_word(lcd_word(clcqs_pkg::CMD_INSTR, clcqs_pkg::MARKER));
		offer_word(lcd_word(clcqs_pkg::CMD_DATA, 8'h00));
		offer_word(lcd_word(clcqs_pkg::CMD_DATA, clcqs_pkg::MARKER));
		offer_word(lcd_word(CMD_UNUSED, 8'hFF));
		play_out_queue();
	endtask

	// A zero delay must still end the wait on the very next tick
	task automatic test_zero_delay();
		write_delay(16'd0);
		offer_word(lcd_word(clcqs_pkg::CMD_DATA, 8'h7E));
		offer_word(lcd_word(clcqs_pkg::CMD_INSTR, 8'h01));
		offer_word(lcd_word(clcqs_pkg::CMD_DATA, clcqs_pkg::MARKER));
		play_out_queue();
	endtask

	// Hold the receiver off while the ring is filled to the brim, so the block
	// backs up and stalls its input; then probe the overflow rule on both kinds.
	// The ring is left full: nothing runs after this test.
	task automatic test_full_queue_backpressure();
		write_delay(16'd0);
		idle_on   = 1'b0;
		hold_left = 400;
		// two bytes per instruction, one byte left free
		for (int i = 0; i < (RING_DEPTH - 2) / 2; i++)
			offer_word(lcd_word(clcqs_pkg::CMD_INSTR, 8'($urandom)));
		// one free byte left: the instruction cannot fit, a character can
		offer_word(lcd_word(clcqs_pkg::CMD_INSTR, 8'($urandom)));
		offer_word(lcd_word(clcqs_pkg::CMD_DATA, 8'($urandom)));
		// ring now full: both kinds are turned away
		offer_word(lcd_word(clcqs_pkg::CMD_DATA, 8'($urandom)));
		offer_word(lcd_word(clcqs_pkg::CMD_INSTR, 8'($urandom)));
		idle_on = 1'b1;
		wait_results_drained();
	endtask

	// Mixed traffic in phases with small delays; one phase runs with no idling at all
	task automatic test_random_traffic();
		for (int phase = 0; phase < 2; phase++) begin
			write_delay(16'($urandom_range(0, 2)));
			idle_on = (phase != 1);
			for (int i = 0; i < 16; i++)
				offer_word(random_lcd_word());
			play_out_queue();
			idle_on = 1'b1;
		end
	endtask

	initial begin
		arst_n      <= 1'b0;
		req_valid   <= 1'b0;
		req         <= '0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		reset_lcd_model();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_delay();
		test_field_extremes();
		test_zero_delay();
		test_random_traffic();
		test_full_queue_backpressure();

		wait_results_drained();
		if (awaited_words.size() != 0)
			flag_mismatch($sformatf("%0d words never arrived", awaited_words.size()));
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
